// ----- rtl/core/frs_pkg.sv -----
// ----------------------------------------------------------------------------
// frs_pkg
// Shared types, constants and helpers of the fall recovery sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

   localparam int MAX_STEPS = 16;
   localparam int TBL_DEPTH = 2 * MAX_STEPS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int POS_W     = TBL_AW + 6;

   localparam int CNT_W = 21;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [4:0] LEN_CAP = (MAX_STEPS < 16) ? 5'(MAX_STEPS) : 5'd16;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_STEP   = 2'd2;

   localparam logic [2:0] REG_ENABLE       = 3'd0;
   localparam logic [2:0] REG_FALLEN_TH    = 3'd1;
   localparam logic [2:0] REG_STANDING_TH  = 3'd2;
   localparam logic [2:0] REG_ORIENT_TH    = 3'd3;
   localparam logic [2:0] REG_DEFAULT_TICK = 3'd4;
   localparam logic [2:0] REG_SETTLE_TICK  = 3'd5;
   localparam logic [2:0] REG_FRONT_LEN    = 3'd6;
   localparam logic [2:0] REG_BACK_LEN     = 3'd7;

   typedef enum logic [1:0] {
      MODE_STANDING,
      MODE_FALLEN,
      MODE_RECOVERING,
      MODE_STABILIZING
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_CMP,
      S_EVAL,
      S_FALL_RD,
      S_FALL_DAT,
      S_STEP_RD,
      S_STEP_RD2,
      S_STEP_DAT,
      S_OUT
   } fsm_type;

   typedef struct packed {
      logic        enable;
      logic [14:0] fallen_threshold;
      logic [14:0] standing_threshold;
      logic [14:0] orient_threshold;
      logic [15:0] default_step_ticks;
      logic [15:0] settle_ticks;
      logic [4:0]  front_length;
      logic [4:0]  back_length;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enable:             1'b1,
      fallen_threshold:   15'd4096,
      standing_threshold: 15'd1229,
      orient_threshold:   15'd4096,
      default_step_ticks: 16'd50,
      settle_ticks:       16'd100,
      front_length:       5'd0,
      back_length:        5'd0
   };

   typedef struct packed {
      logic front;
      logic fallen;
      logic standing;
   } tilt_type;

   typedef struct packed {
      logic              wr_en;
      logic [TBL_AW-1:0] wr_addr;
      logic [15:0]       wr_data;
      logic [TBL_AW-1:0] rd_addr;
   } tbl_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        standing;
      logic        recovering;
      logic        seq;
      logic [3:0]  idx;
      logic [15:0] ticks;
      logic        last;
   } rsp_type;

   localparam rsp_type RSP_NONE = '{
      kind: KIND_NONE, standing: 1'b0, recovering: 1'b0, seq: 1'b0,
      idx: 4'd0, ticks: 16'd0, last: 1'b1
   };

   function automatic logic [TBL_AW-1:0] tbl_addr(logic seq, logic [4:0] idx);
      logic [POS_W-1:0] pos;
      pos = POS_W'(seq) * POS_W'(MAX_STEPS) + POS_W'(idx);
      return pos[TBL_AW-1:0];
   endfunction

   function automatic logic [15:0] eff_dur(logic [15:0] stored, logic [15:0] dflt);
      if (stored != 16'd0) begin
         return stored;
      end else if (dflt != 16'd0) begin
         return dflt;
      end
      return 16'd1;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic logic [4:0] seq_len(cfg_type c, logic seq);
      logic [4:0] len;
      len = seq ? c.front_length : c.back_length;
      return (len > LEN_CAP) ? LEN_CAP : len;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/frs_csr.sv -----
// ----------------------------------------------------------------------------
// frs_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [frs_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [frs_pkg::CSR_DW-1:0]  csr_pwdata,
   output      logic [frs_pkg::CSR_DW-1:0]  csr_prdata,
   output      logic                        csr_pready,
   output      frs_pkg::cfg_type            cfg
);
   import frs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = csr_paddr[CSR_AW-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_ENABLE:       cfg_in.enable             = csr_pwdata[0];
            REG_FALLEN_TH:    cfg_in.fallen_threshold   = csr_pwdata[14:0];
            REG_STANDING_TH:  cfg_in.standing_threshold = csr_pwdata[14:0];
            REG_ORIENT_TH:    cfg_in.orient_threshold   = csr_pwdata[14:0];
            REG_DEFAULT_TICK: cfg_in.default_step_ticks = csr_pwdata[15:0];
            REG_SETTLE_TICK:  cfg_in.settle_ticks       = csr_pwdata[15:0];
            REG_FRONT_LEN:    cfg_in.front_length       = csr_pwdata[4:0];
            REG_BACK_LEN:     cfg_in.back_length        = csr_pwdata[4:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ENABLE:       csr_prdata = CSR_DW'(cfg_ff.enable);
         REG_FALLEN_TH:    csr_prdata = CSR_DW'(cfg_ff.fallen_threshold);
         REG_STANDING_TH:  csr_prdata = CSR_DW'(cfg_ff.standing_threshold);
         REG_ORIENT_TH:    csr_prdata = CSR_DW'(cfg_ff.orient_threshold);
         REG_DEFAULT_TICK: csr_prdata = CSR_DW'(cfg_ff.default_step_ticks);
         REG_SETTLE_TICK:  csr_prdata = CSR_DW'(cfg_ff.settle_ticks);
         REG_FRONT_LEN:    csr_prdata = CSR_DW'(cfg_ff.front_length);
         REG_BACK_LEN:     csr_prdata = CSR_DW'(cfg_ff.back_length);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/frs_table.sv -----
// ----------------------------------------------------------------------------
// frs_table
// Step duration memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_table (
   input  wire logic                 clock,
   input  wire frs_pkg::tbl_req_type req,
   output      logic [15:0]          rd_data
);
   import frs_pkg::*;

   logic [15:0] mem [TBL_DEPTH];
   logic [15:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem[req.rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/frs_tilt.sv -----
// ----------------------------------------------------------------------------
// frs_tilt
// Two-stage tilt test: squares, then sum and threshold compares.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_tilt (
   input  wire logic                clock,
   input  wire logic signed [15:0]  roll,
   input  wire logic signed [15:0]  pitch,
   input  wire frs_pkg::cfg_type    cfg,
   output      frs_pkg::tilt_type   flags
);
   import frs_pkg::*;

   logic signed [31:0] roll_prod, pitch_prod;
   logic [30:0]        roll_sq_ff, pitch_sq_ff;
   logic [29:0]        fth2_ff, sth2_ff, fth2_in, sth2_in;
   logic signed [15:0] roll_d_ff;
   logic [31:0]        mag2;
   tilt_type           flags_ff, flags_in;

   assign roll_prod  = roll * roll;
   assign pitch_prod = pitch * pitch;
   assign fth2_in    = 30'(cfg.fallen_threshold) * 30'(cfg.fallen_threshold);
   assign sth2_in    = 30'(cfg.standing_threshold) * 30'(cfg.standing_threshold);

   assign mag2 = 32'(roll_sq_ff) + 32'(pitch_sq_ff);

   always_comb begin
      flags_in.fallen   = mag2 > 32'(fth2_ff);
      flags_in.standing = mag2 < 32'(sth2_ff);
      flags_in.front    = $signed({roll_d_ff[15], roll_d_ff}) >
                          $signed({2'b00, cfg.orient_threshold});
   end

   assign flags = flags_ff;

   always_ff @(posedge clock) begin
      roll_sq_ff  <= roll_prod[30:0];
      pitch_sq_ff <= pitch_prod[30:0];
      fth2_ff     <= fth2_in;
      sth2_ff     <= sth2_in;
      roll_d_ff   <= roll;
      flags_ff    <= flags_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/frs_ctrl.sv -----
// ----------------------------------------------------------------------------
// frs_ctrl
// Mode machine and step sequencer; reads durations from the table memory.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire frs_pkg::cfg_type                 cfg,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [frs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                             req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [frs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output      logic [1:0]                       rsp_tuser,
   output      logic                             rsp_tlast,
   output      logic signed [15:0]               roll,
   output      logic signed [15:0]               pitch,
   input  wire frs_pkg::tilt_type                flags,
   output      frs_pkg::tbl_req_type             tbl_req,
   input  wire logic [15:0]                      tbl_rd_data
);
   import frs_pkg::*;

   fsm_type           state_ff, state_in, after_ff, after_in;
   mode_type          mode_ff, mode_in;
   logic              seq_ff, seq_in;
   logic [4:0]        step_ff, step_in;
   logic [CNT_W-1:0]  elapsed_ff, elapsed_in, deadline_ff, deadline_in;
   logic [15:0]       cur_dur_ff, cur_dur_in;
   logic signed [15:0] roll_ff, roll_in, pitch_ff, pitch_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_joints, req_seq;
   logic [3:0]        req_step;
   logic [15:0]       req_dur;
   logic [4:0]        len, step_nx;
   logic [CNT_W-1:0]  elapsed_inc, dl_sum, new_dl;
   logic [15:0]       dur_eff;
   logic              go, k1_ok, more;

   assign req_joints = req_tdata[32];
   assign req_seq    = req_tdata[33];
   assign req_step   = req_tdata[37:34];
   assign req_dur    = req_tdata[53:38];

   assign len         = seq_len(cfg, seq_ff);
   assign step_nx     = step_ff + 5'd1;
   assign elapsed_inc = sat_add(elapsed_ff, CNT_W'(1));
   assign dur_eff     = eff_dur(tbl_rd_data, cfg.default_step_ticks);
   assign dl_sum      = sat_add(deadline_ff, CNT_W'(dur_eff));
   assign go          = (step_ff < len) && (elapsed_inc >= deadline_ff);
   assign k1_ok       = step_nx < len;
   assign new_dl      = k1_ok ? dl_sum : deadline_ff;
   assign more        = k1_ok && (elapsed_ff >= new_dl);

   assign roll       = roll_ff;
   assign pitch      = pitch_ff;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {1'b0, rsp_ff.ticks, rsp_ff.idx, rsp_ff.seq,
                        rsp_ff.recovering, rsp_ff.standing};

   always_comb begin
      state_in    = state_ff;
      after_in    = after_ff;
      mode_in     = mode_ff;
      seq_in      = seq_ff;
      step_in     = step_ff;
      elapsed_in  = elapsed_ff;
      deadline_in = deadline_ff;
      cur_dur_in  = cur_dur_ff;
      roll_in     = roll_ff;
      pitch_in    = pitch_ff;
      rsp_in      = rsp_ff;
      req_tready  = 1'b0;
      tbl_req.wr_en   = 1'b0;
      tbl_req.wr_addr = tbl_addr(req_seq, {1'b0, req_step});
      tbl_req.wr_data = req_dur;
      tbl_req.rd_addr = tbl_addr(seq_ff, step_ff);

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               roll_in  = req_tdata[15:0];
               pitch_in = req_tdata[31:16];
               if (req_tuser == OP_LOAD) begin
                  tbl_req.wr_en = int'(req_step) < MAX_STEPS;
                  rsp_in   = RSP_NONE;
                  state_in = S_OUT;
                  after_in = S_IDLE;
               end else if (!cfg.enable || !req_joints) begin
                  rsp_in   = RSP_NONE;
                  state_in = S_OUT;
                  after_in = S_IDLE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: state_in = S_CMP;
         S_CMP: state_in = S_EVAL;
         S_EVAL: begin
            unique case (mode_ff)
               MODE_STANDING: begin
                  rsp_in = '{kind: KIND_STATUS, standing: 1'b1, recovering: 1'b0,
                             seq: 1'b0, idx: 4'd0, ticks: 16'd0, last: 1'b1};
                  if (flags.fallen) begin
                     mode_in = MODE_FALLEN;
                  end
                  state_in = S_OUT;
                  after_in = S_IDLE;
               end
               MODE_FALLEN: begin
                  seq_in      = flags.front;
                  step_in     = 5'd0;
                  elapsed_in  = '0;
                  mode_in     = MODE_RECOVERING;
                  state_in    = S_FALL_RD;
               end
               MODE_RECOVERING: begin
                  rsp_in = '{kind: KIND_STATUS, standing: 1'b0, recovering: 1'b1,
                             seq: 1'b0, idx: 4'd0, ticks: 16'd0, last: !go};
                  elapsed_in = elapsed_inc;
                  if (!go && step_ff >= len) begin
                     mode_in    = MODE_STABILIZING;
                     elapsed_in = '0;
                  end
                  state_in = S_OUT;
                  after_in = go ? S_STEP_RD : S_IDLE;
               end
               MODE_STABILIZING: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > CNT_W'(cfg.settle_ticks)) begin
                     if (flags.standing) begin
                        mode_in = MODE_STANDING;
                     end else if (flags.fallen) begin
                        mode_in = MODE_FALLEN;
                     end
                  end
                  rsp_in   = RSP_NONE;
                  state_in = S_OUT;
                  after_in = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FALL_RD: state_in = S_FALL_DAT;
         S_FALL_DAT: begin
            deadline_in = (len != 5'd0) ? CNT_W'(dur_eff) : '0;
            rsp_in      = RSP_NONE;
            state_in    = S_OUT;
            after_in    = S_IDLE;
         end
         S_STEP_RD: state_in = S_STEP_RD2;
         S_STEP_RD2: begin
            cur_dur_in      = dur_eff;
            tbl_req.rd_addr = tbl_addr(seq_ff, step_nx);
            state_in        = S_STEP_DAT;
         end
         S_STEP_DAT: begin
            rsp_in = '{kind: KIND_STEP, standing: 1'b0, recovering: 1'b0,
                       seq: seq_ff, idx: step_ff[3:0], ticks: cur_dur_ff,
                       last: !more};
            step_in     = step_nx;
            deadline_in = new_dl;
            if (!k1_ok) begin
               mode_in    = MODE_STABILIZING;
               elapsed_in = '0;
            end
            state_in = S_OUT;
            after_in = more ? S_STEP_RD : S_IDLE;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = after_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         after_ff    <= S_IDLE;
         mode_ff     <= MODE_STANDING;
         seq_ff      <= 1'b0;
         step_ff     <= 5'd0;
         elapsed_ff  <= '0;
         deadline_ff <= '0;
      end else begin
         state_ff    <= state_in;
         after_ff    <= after_in;
         mode_ff     <= mode_in;
         seq_ff      <= seq_in;
         step_ff     <= step_in;
         elapsed_ff  <= elapsed_in;
         deadline_ff <= deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_dur_ff <= cur_dur_in;
      roll_ff    <= roll_in;
      pitch_ff   <= pitch_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/fall_recovery_sequencer.sv -----
// ----------------------------------------------------------------------------
// fall_recovery_sequencer
// Tilt-driven standing / fallen / getting-up / stabilizing sequencer.
// ----------------------------------------------------------------------------
// One item is handled at a time. A table load or an ignored tick shows its
// single result in the cycle after acceptance. A control tick passes through
// the two squared-tilt multiply and compare stages and an evaluate state before
// its first result; the tick that leaves the fallen mode adds a read of the
// first step duration. While getting up, each issued step reads this step's
// duration and the next one through the single read port of the duration
// memory, and then presents the step. The next item is taken in the cycle after
// the last result of an item is accepted. The duration memory is not cleared
// after reset; load every entry that a configured sequence length will reach.
// ----------------------------------------------------------------------------
`default_nettype none

module fall_recovery_sequencer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [15:0] tilt_roll, [31:16] tilt_pitch, [32] joints_seen, [33] table_sequence,
   // [37:34] table_step, [53:38] table_duration, [55:54] zero
   input  wire logic [frs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] opcode
   input  wire logic                             req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] standing, [1] recovering, [2] sequence_res, [6:3] step_index,
   // [22:7] step_ticks, [23] zero
   output      logic [frs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] kind
   output      logic [1:0]                       rsp_tuser,
   output      logic                             rsp_tlast,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [frs_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [frs_pkg::CSR_DW-1:0]       csr_pwdata,
   output      logic [frs_pkg::CSR_DW-1:0]       csr_prdata,
   output      logic                             csr_pready
);
   import frs_pkg::*;

   cfg_type            cfg;
   tilt_type           flags;
   tbl_req_type        tbl_req;
   logic [15:0]        tbl_rd_data;
   logic signed [15:0] roll, pitch;

   frs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   frs_tilt u_tilt (
      .clock (clock),
      .roll  (roll),
      .pitch (pitch),
      .cfg   (cfg),
      .flags (flags)
   );

   frs_table u_table (
      .clock   (clock),
      .req     (tbl_req),
      .rd_data (tbl_rd_data)
   );

   frs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .roll        (roll),
      .pitch       (pitch),
      .flags       (flags),
      .tbl_req     (tbl_req),
      .tbl_rd_data (tbl_rd_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/frs_checker.sv -----
// ----------------------------------------------------------------------------
// frs_checker
// Port-level checks of the fall recovery sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [frs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [1:0]                       rsp_tuser,
   input wire logic                             rsp_tlast
);
   import frs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid)
      else $error("item accepted while a result is pending");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_LOAD |=>
         rsp_tvalid && rsp_tuser == KIND_NONE && rsp_tlast)
      else $error("table load did not give one empty result");

   a_status_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tdata[0] ^ rsp_tdata[1])
      else $error("status item not standing xor recovering");

   a_step_ticks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STEP |-> rsp_tdata[22:7] != 16'd0)
      else $error("step issued with zero duration");

endmodule

bind fall_recovery_sequencer frs_checker u_frs_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fall recovery sequencer: directed and random
// tilt ticks and duration loads go in over the request stream, every result
// item is compared with a cycle-free model of the recovery machine, and the
// register set is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import frs_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic        opcode;
      logic [15:0] roll;
      logic [15:0] pitch;
      logic        joints_seen;
      logic        table_seq;
      logic [3:0]  table_step;
      logic [15:0] table_dur;
   } tick_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire logic             req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   wire logic             rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire logic [RSP_DATA_W-1:0] rsp_tdata;
   wire logic [1:0]       rsp_tuser;
   wire logic             rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   wire logic [CSR_DW-1:0] csr_prdata;
   wire logic             csr_pready;

   cfg_type           shadow_cfg = CFG_RESET;
   mode_type          pred_mode = MODE_STANDING;
   logic              pred_seq = 1'b0;
   logic [4:0]        pred_next = '0;
   logic [CNT_W-1:0]  pred_elapsed = '0;
   logic [CNT_W-1:0]  pred_deadline = '0;
   logic [15:0]       step_table [2][MAX_STEPS];
   rsp_type           awaited_reports [$];

   bit bursts_on = 1'b1;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int stall_left = 0;
   int items_sent = 0;
   int results_checked = 0;
   int settings_applied = 0;
   int fail_count = 0;
   int cycle_count = 0;

   fall_recovery_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [CNT_W-1:0] add_clamped(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   function automatic logic [4:0] active_len(logic sq);
      int n;
      int cap;
      n = sq ? int'(shadow_cfg.front_length) : int'(shadow_cfg.back_length);
      cap = (MAX_STEPS < 16) ? MAX_STEPS : 16;
      return 5'((n > cap) ? cap : n);
   endfunction

   function automatic logic [15:0] step_length(logic sq, logic [4:0] ix);
      logic [15:0] d;
      d = (ix < MAX_STEPS) ? step_table[sq][ix[3:0]] : 16'd0;
      if (d == 16'd0) d = shadow_cfg.default_step_ticks;
      if (d == 16'd0) d = 16'd1;
      return d;
   endfunction

   function automatic rsp_type report(logic [1:0] kind, logic st, logic gu, logic sq,
                                      logic [3:0] ix, logic [15:0] tk);
      rsp_type r;
      r.kind = kind;
      r.standing = st;
      r.recovering = gu;
      r.seq = sq;
      r.idx = ix;
      r.ticks = tk;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void predict_recovery(tick_cmd_type cmd);
      longint     roll_v;
      longint     pitch_v;
      longint     mag2;
      longint     lim;
      logic       tilt_fallen;
      logic       tilt_standing;
      logic [4:0] len;
      rsp_type    batch [$];
      rsp_type    item;
      roll_v = longint'($signed(cmd.roll));
      pitch_v = longint'($signed(cmd.pitch));
      mag2 = roll_v * roll_v + pitch_v * pitch_v;
      lim = longint'(shadow_cfg.fallen_threshold);
      tilt_fallen = mag2 > lim * lim;
      lim = longint'(shadow_cfg.standing_threshold);
      tilt_standing = mag2 < lim * lim;
      if (cmd.opcode == OP_LOAD) begin
         step_table[cmd.table_seq][cmd.table_step] = cmd.table_dur;
      end else if (shadow_cfg.enable && cmd.joints_seen) begin
         case (pred_mode)
            MODE_STANDING: begin
               batch = {batch, report(KIND_STATUS, 1'b1, 1'b0, 1'b0, 4'd0, 16'd0)};
               if (tilt_fallen) pred_mode = MODE_FALLEN;
            end
            MODE_FALLEN: begin
               pred_seq = roll_v > longint'(shadow_cfg.orient_threshold);
               pred_next = '0;
               pred_elapsed = '0;
               pred_deadline = (active_len(pred_seq) > 0) ?
                               CNT_W'(step_length(pred_seq, 5'd0)) : '0;
               pred_mode = MODE_RECOVERING;
            end
            MODE_RECOVERING: begin
               batch = {batch, report(KIND_STATUS, 1'b0, 1'b1, 1'b0, 4'd0, 16'd0)};
               pred_elapsed = add_clamped(pred_elapsed, CNT_W'(1));
               len = active_len(pred_seq);
               while (pred_next < len && pred_elapsed >= pred_deadline) begin
                  batch = {batch, report(KIND_STEP, 1'b0, 1'b0, pred_seq, pred_next[3:0],
                                         step_length(pred_seq, pred_next))};
                  pred_next++;
                  if (pred_next < len)
                     pred_deadline = add_clamped(pred_deadline,
                                                 CNT_W'(step_length(pred_seq, pred_next)));
               end
               if (pred_next >= len) begin
                  pred_mode = MODE_STABILIZING;
                  pred_elapsed = '0;
               end
            end
            default: begin
               pred_elapsed = add_clamped(pred_elapsed, CNT_W'(1));
               if (pred_elapsed > CNT_W'(shadow_cfg.settle_ticks)) begin
                  if (tilt_standing) pred_mode = MODE_STANDING;
                  else if (tilt_fallen) pred_mode = MODE_FALLEN;
               end
            end
         endcase
      end
      if (batch.size() == 0)
         batch = {batch, report(KIND_NONE, 1'b0, 1'b0, 1'b0, 4'd0, 16'd0)};
      foreach (batch[i]) begin
         item = batch[i];
         item.last = (i == batch.size() - 1);
         awaited_reports = {awaited_reports, item};
      end
   endfunction

   // -------------------------------------------------------------- checker

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_report();
      rsp_type want;
      if (awaited_reports.size() == 0) begin
         $error("result item with no expectation (kind %0d)", rsp_tuser);
         fail_count++;
      end else begin
         want = awaited_reports.pop_front();
         results_checked++;
         compare_field("kind", 32'(want.kind), 32'(rsp_tuser));
         compare_field("standing", 32'(want.standing), 32'(rsp_tdata[0]));
         compare_field("recovering", 32'(want.recovering), 32'(rsp_tdata[1]));
         compare_field("sequence_res", 32'(want.seq), 32'(rsp_tdata[2]));
         compare_field("step_index", 32'(want.idx), 32'(rsp_tdata[6:3]));
         compare_field("step_ticks", 32'(want.ticks), 32'(rsp_tdata[22:7]));
         compare_field("last", 32'(want.last), 32'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_report();
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------- stimulus

   function automatic tick_cmd_type tick_cmd(logic [15:0] roll, logic [15:0] pitch,
                                             logic joints);
      tick_cmd_type c;
      c.opcode = OP_TICK;
      c.roll = roll;
      c.pitch = pitch;
      c.joints_seen = joints;
      c.table_seq = 1'($urandom());
      c.table_step = 4'($urandom());
      c.table_dur = 16'($urandom());
      return c;
   endfunction

   function automatic tick_cmd_type load_cmd(logic sq, logic [3:0] st, logic [15:0] dur);
      tick_cmd_type c;
      c.opcode = OP_LOAD;
      c.roll = 16'($urandom());
      c.pitch = 16'($urandom());
      c.joints_seen = 1'($urandom());
      c.table_seq = sq;
      c.table_step = st;
      c.table_dur = dur;
      return c;
   endfunction

   function automatic logic [15:0] random_tilt();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = int'($urandom_range(0, 1600)) - 800;
         2, 3: v = int'($urandom_range(5000, 32767)) * (($urandom_range(0, 1) != 0) ? -1 : 1);
         4: v = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
         default: v = int'($urandom());
      endcase
      return v[15:0];
   endfunction

   function automatic tick_cmd_type random_item();
      if ($urandom_range(0, 6) == 0)
         return load_cmd(1'($urandom()), 4'($urandom()), 16'($urandom_range(0, 3)));
      return tick_cmd(random_tilt(), random_tilt(), $urandom_range(0, 15) != 0);
   endfunction

   function automatic logic [14:0] pick_threshold(int lo, int hi);
      case ($urandom_range(0, 7))
         0: return 15'd0;
         1: return 15'h7FFF;
         2: return 15'($urandom());
         default: return 15'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic logic [4:0] pick_length();
      case ($urandom_range(0, 7))
         0: return 5'd0;
         1: return 5'd16;
         2: return 5'($urandom_range(17, 31));
         default: return 5'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.enable = ($urandom_range(0, 7) != 0);
      c.fallen_threshold = pick_threshold(2000, 9000);
      c.standing_threshold = pick_threshold(300, 2500);
      c.orient_threshold = pick_threshold(0, 8000);
      c.default_step_ticks = 16'($urandom_range(0, 3));
      c.settle_ticks = 16'($urandom_range(0, 4));
      c.front_length = pick_length();
      c.back_length = pick_length();
      return c;
   endfunction

   task automatic send_item(input tick_cmd_type cmd);
      int gap;
      gap = (bursts_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd.opcode;
      req_tdata <= {2'b00, cmd.table_dur, cmd.table_step, cmd.table_seq, cmd.joints_seen,
                    cmd.pitch, cmd.roll};
      do @(posedge clock); while (!req_tready);
      predict_recovery(cmd);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_ENABLE:       shadow_cfg.enable = value[0];
         REG_FALLEN_TH:    shadow_cfg.fallen_threshold = value[14:0];
         REG_STANDING_TH:  shadow_cfg.standing_threshold = value[14:0];
         REG_ORIENT_TH:    shadow_cfg.orient_threshold = value[14:0];
         REG_DEFAULT_TICK: shadow_cfg.default_step_ticks = value[15:0];
         REG_SETTLE_TICK:  shadow_cfg.settle_ticks = value[15:0];
         REG_FRONT_LEN:    shadow_cfg.front_length = value[4:0];
         REG_BACK_LEN:     shadow_cfg.back_length = value[4:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input cfg_type c);
      wait_idle();
      write_reg(REG_ENABLE, CSR_DW'(c.enable));
      write_reg(REG_FALLEN_TH, CSR_DW'(c.fallen_threshold));
      write_reg(REG_STANDING_TH, CSR_DW'(c.standing_threshold));
      write_reg(REG_ORIENT_TH, CSR_DW'(c.orient_threshold));
      write_reg(REG_DEFAULT_TICK, CSR_DW'(c.default_step_ticks));
      write_reg(REG_SETTLE_TICK, CSR_DW'(c.settle_ticks));
      write_reg(REG_FRONT_LEN, CSR_DW'(c.front_length));
      write_reg(REG_BACK_LEN, CSR_DW'(c.back_length));
      settings_applied++;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_behavior();
      send_item(tick_cmd(16'd0, 16'd0, 1'b1));
      send_item(tick_cmd(16'h8000, 16'h8000, 1'b0));
      send_item(tick_cmd(16'h8000, 16'h8000, 1'b1));
      send_item(tick_cmd(16'h7FFF, 16'd0, 1'b1));
      send_item(tick_cmd(16'd0, 16'd0, 1'b1));
   endtask

   task automatic test_table_load();
      send_item(load_cmd(1'b0, 4'd15, 16'hFFFF));
      send_item(load_cmd(1'b1, 4'd0, 16'hFFFF));
      for (int s = 0; s < 2; s++)
         for (int k = 0; k < MAX_STEPS; k++)
            send_item(load_cmd(1'(s), 4'(k), 16'($urandom_range(0, 3))));
      send_item(load_cmd(1'b1, 4'd1, 16'd0));
   endtask

   task automatic test_recovery_paths();
      apply_config('{enable: 1'b1, fallen_threshold: 15'd4096, standing_threshold: 15'd1229,
                     orient_threshold: 15'd2048, default_step_ticks: 16'd0,
                     settle_ticks: 16'd1, front_length: 5'd3, back_length: 5'd2});
      repeat (3) send_item(tick_cmd(16'd100, -16'sd100, 1'b1));
      send_item(tick_cmd(16'd0, 16'd0, 1'b1));
      send_item(tick_cmd(16'd20000, -16'sd5000, 1'b1));
      send_item(tick_cmd(16'd20000, 16'd0, 1'b1));
      repeat (8) send_item(tick_cmd(16'd300, 16'd0, 1'b1));
      repeat (3) send_item(tick_cmd(-16'sd30000, 16'h7FFF, 1'b1));
      send_item(tick_cmd(-16'sd30000, 16'd0, 1'b1));
      repeat (6) send_item(tick_cmd(16'd0, 16'd0, 1'b1));
   endtask

   task automatic test_enable_off();
      cfg_type c;
      c = shadow_cfg;
      c.enable = 1'b0;
      apply_config(c);
      send_item(tick_cmd(16'h8000, 16'h7FFF, 1'b1));
      send_item(tick_cmd(16'd0, 16'd0, 1'b1));
      send_item(tick_cmd(16'h7FFF, 16'h8000, 1'b0));
   endtask

   task automatic test_register_extremes();
      apply_config('{enable: 1'b1, fallen_threshold: 15'h7FFF, standing_threshold: 15'h7FFF,
                     orient_threshold: 15'h7FFF, default_step_ticks: 16'hFFFF,
                     settle_ticks: 16'hFFFF, front_length: 5'd0, back_length: 5'd0});
      send_item(tick_cmd(16'h8000, 16'h8000, 1'b1));
      send_item(tick_cmd(16'h8000, 16'd0, 1'b1));
      send_item(tick_cmd(16'h7FFF, 16'h7FFF, 1'b1));
      send_item(tick_cmd(16'd0, 16'd0, 1'b1));
   endtask

   task automatic test_output_backpressure();
      apply_config(random_config());
      hold_requests++;
      repeat (20) send_item(random_item());
   endtask

   task automatic test_random_recovery();
      for (int phase = 0; phase < 8; phase++) begin
         apply_config(random_config());
         bursts_on = (phase < 6);
         repeat (17) send_item(random_item());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_behavior();
      test_table_load();
      test_recovery_paths();
      test_enable_off();
      test_register_extremes();
      test_output_backpressure();
      test_random_recovery();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("sent %0d input items over %0d register settings, checked %0d result items",
               items_sent, settings_applied, results_checked);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/frs_pkg.sv
rtl/core/frs_csr.sv
rtl/core/frs_table.sv
rtl/core/frs_tilt.sv
rtl/core/frs_ctrl.sv
rtl/core/fall_recovery_sequencer.sv
rtl/core/frs_checker.sv
tb/tb_top.sv
